// File: sv/assert_macros.svh
// Assertion macros used by the complex FIR filter core.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/cfir_pkg.sv
// Package for the complex FIR filter: widths, command codes and the
// command and status structs between controller and datapath. No dependencies.
package cfir_pkg;

    localparam int MAX_TAPS = 64;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = $clog2(MAX_TAPS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ACC_W    = SUM_W + IDX_W + 1;
    localparam int SHIFT    = COEF_W - 1;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_W - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MODE = 2'd1;

    typedef struct packed {
        logic             tap_wr;
        logic             dl_clear;
        logic             start;
        logic             issue;
        logic             first;
        logic [IDX_W-1:0] rd_k;
        logic             finish;
        logic             real_mode;
    } cfir_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } cfir_sts_t;

endpackage

// File: sv/cfir_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cfir_ctrl.sv
// Controller of the complex FIR filter: configuration registers, the tap
// sequencer state machine and the input handshake. Depends on cfir_pkg.
module cfir_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cfir_pkg::CMD_W-1:0]         cmd,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfir_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cfir_pkg::cfir_cmd_t                dp_cmd,
    input  cfir_pkg::cfir_sts_t                dp_sts
);
    import cfir_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0] tap_count_reg, tap_count_next;
    logic             real_mode_reg, real_mode_next;
    logic [CNT_W-1:0] m_clamp;
    logic             accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            m_clamp = CNT_W'(1);
        end
        else if (tap_count_reg > CNT_W'(MAX_TAPS))
        begin
            m_clamp = CNT_W'(MAX_TAPS);
        end
        else
        begin
            m_clamp = tap_count_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        tap_count_next = tap_count_reg;
        real_mode_next = real_mode_reg;

        dp_cmd           = '0;
        dp_cmd.real_mode = real_mode_reg;
        dp_cmd.rd_k      = k_reg[IDX_W-1:0];
        dp_cmd.first     = (k_reg == '0);

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TAP_COUNT)
            begin
                tap_count_next = CNT_W'(cfg_data);
            end
            else if (cfg_index == REG_REAL_MODE)
            begin
                real_mode_next = cfg_data[0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_FILTER)
                    begin
                        dp_cmd.start = 1'b1;
                        k_next       = '0;
                        m_next       = m_clamp;
                        state_next   = ST_ISSUE;
                    end
                    else if (cmd == CMD_LOAD)
                    begin
                        dp_cmd.tap_wr = 1'b1;
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        dp_cmd.dl_clear = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                dp_cmd.issue = 1'b1;
                k_next       = k_reg + CNT_W'(1);
                if (k_next == m_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_sts.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!dp_sts.out_busy)
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            m_reg         <= CNT_W'(1);
            tap_count_reg <= CNT_W'(1);
            real_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            tap_count_reg <= tap_count_next;
            real_mode_reg <= real_mode_next;
        end
    end

endmodule

// File: sv/cfir_dp.sv
// Datapath of the complex FIR filter: tap and delay-line memories, the shared
// complex multiply-accumulate, rounding, saturation and the output register.
// Depends on cfir_pkg and cfir_ram.
module cfir_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cfir_pkg::cfir_cmd_t                  dp_cmd,
    output cfir_pkg::cfir_sts_t                  dp_sts,
    input  logic signed [cfir_pkg::SAMPLE_W-1:0] sample_i,
    input  logic signed [cfir_pkg::SAMPLE_W-1:0] sample_q,
    input  logic        [cfir_pkg::IDX_W-1:0]    tap_index,
    input  logic signed [cfir_pkg::COEF_W-1:0]   tap_re,
    input  logic signed [cfir_pkg::COEF_W-1:0]   tap_im,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cfir_pkg::SAMPLE_W-1:0] out_i,
    output logic signed [cfir_pkg::SAMPLE_W-1:0] out_q,
    output logic                                 clipped
);
    import cfir_pkg::*;

    logic [2*COEF_W-1:0]   tap_rd;
    logic [2*SAMPLE_W-1:0] dl_rd;
    logic [IDX_W-1:0]      dl_rd_addr;

    logic [IDX_W-1:0]      wp_reg;
    logic [MAX_TAPS-1:0]   dl_vld_reg;
    logic                  dlv_reg;
    logic                  first_reg;
    logic                  rd_vld_reg;
    logic                  prod_vld_reg;
    logic                  sum_vld_reg;

    logic signed [SAMPLE_W-1:0] x_i_reg, x_q_reg;
    logic signed [SAMPLE_W-1:0] si, sq;
    logic signed [COEF_W-1:0]   hr, hm;

    logic signed [PROD_W-1:0] p_rr_reg, p_mq_reg, p_rq_reg, p_mi_reg;
    logic signed [SUM_W-1:0]  s_i_reg, s_q_reg;
    logic signed [ACC_W-1:0]  acc_i_reg, acc_q_reg;
    logic signed [ACC_W-1:0]  sh_i, sh_q;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_i_reg, out_q_reg, y_i, y_q;
    logic                       clipped_reg, clip_i, clip_q;

    assign dl_rd_addr = wp_reg - dp_cmd.rd_k;

    cfir_ram #(
        .WIDTH (2 * COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk     (clk),
        .wr_en   (dp_cmd.tap_wr),
        .wr_addr (tap_index),
        .wr_data ({tap_re, tap_im}),
        .rd_en   (dp_cmd.issue),
        .rd_addr (dp_cmd.rd_k),
        .rd_data (tap_rd)
    );

    cfir_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_dl_ram (
        .clk     (clk),
        .wr_en   (dp_cmd.finish),
        .wr_addr (wp_reg),
        .wr_data ({x_i_reg, x_q_reg}),
        .rd_en   (dp_cmd.issue),
        .rd_addr (dl_rd_addr),
        .rd_data (dl_rd)
    );

    always_comb
    begin
        hr = tap_rd[2*COEF_W-1:COEF_W];
        hm = dp_cmd.real_mode ? '0 : tap_rd[COEF_W-1:0];
        if (first_reg)
        begin
            si = x_i_reg;
            sq = x_q_reg;
        end
        else if (dlv_reg)
        begin
            si = dl_rd[2*SAMPLE_W-1:SAMPLE_W];
            sq = dl_rd[SAMPLE_W-1:0];
        end
        else
        begin
            si = '0;
            sq = '0;
        end
    end

    always_comb
    begin
        sh_i = (acc_i_reg + RND_HALF) >>> SHIFT;
        sh_q = (acc_q_reg + RND_HALF) >>> SHIFT;
        clip_i = 1'b0;
        clip_q = 1'b0;
        y_i = sh_i[SAMPLE_W-1:0];
        y_q = sh_q[SAMPLE_W-1:0];
        if (sh_i > SAT_HI)
        begin
            y_i    = SAT_HI[SAMPLE_W-1:0];
            clip_i = 1'b1;
        end
        else if (sh_i < SAT_LO)
        begin
            y_i    = SAT_LO[SAMPLE_W-1:0];
            clip_i = 1'b1;
        end
        if (sh_q > SAT_HI)
        begin
            y_q    = SAT_HI[SAMPLE_W-1:0];
            clip_q = 1'b1;
        end
        else if (sh_q < SAT_LO)
        begin
            y_q    = SAT_LO[SAMPLE_W-1:0];
            clip_q = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            x_i_reg <= sample_i;
            x_q_reg <= sample_q;
        end
        if (dp_cmd.issue)
        begin
            first_reg <= dp_cmd.first;
            dlv_reg   <= dl_vld_reg[dl_rd_addr];
        end
        if (rd_vld_reg)
        begin
            p_rr_reg <= hr * si;
            p_mq_reg <= hm * sq;
            p_rq_reg <= hr * sq;
            p_mi_reg <= hm * si;
        end
        if (prod_vld_reg)
        begin
            s_i_reg <= SUM_W'(p_rr_reg) - SUM_W'(p_mq_reg);
            s_q_reg <= SUM_W'(p_rq_reg) + SUM_W'(p_mi_reg);
        end
        if (dp_cmd.start)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (sum_vld_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(s_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(s_q_reg);
        end
        if (dp_cmd.finish)
        begin
            out_i_reg   <= y_i;
            out_q_reg   <= y_q;
            clipped_reg <= clip_i || clip_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            dl_vld_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            sum_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= dp_cmd.issue;
            prod_vld_reg <= rd_vld_reg;
            sum_vld_reg  <= prod_vld_reg;
            if (dp_cmd.dl_clear)
            begin
                dl_vld_reg <= '0;
            end
            else if (dp_cmd.finish)
            begin
                dl_vld_reg[wp_reg] <= 1'b1;
                wp_reg             <= wp_reg + IDX_W'(1);
            end
            if (dp_cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_sts.pipe_busy = rd_vld_reg || prod_vld_reg || sum_vld_reg;
    assign dp_sts.out_busy  = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;
    assign clipped   = clipped_reg;

endmodule

// File: sv/complex_fir_filter_core.sv
// Complex direct-form FIR filter on Q1.15 I/Q samples, with up to 64 taps.
// The input channel carries a command and its operands as one beat: filter a
// sample, load one tap into the tap store, or clear the delay line.
// The output channel carries one beat per filtered sample: out_i, out_q and
// clipped, set when either part saturated after rounding to nearest.
// Configuration writes (tap_count, real_mode) go over the cfg channel, which
// is always ready; they are meant for times when the block is idle.
// A filter beat runs its m taps through the accumulator, where
// m is tap_count held to the range 1 to 64. The single shared complex
// multiply-accumulate reads one tap and one sample per cycle; its pipeline
// then drains and the result is written into the output register. A new
// filter beat is accepted only after that write.
// Load, clear and unused commands complete in the cycle they are accepted.
// in_stall is high while a sample is being filtered. A finished result waits
// in the output register; while the receiver stalls, the next beat can be
// accepted and computed, and only its write into the output register waits.
// Reset empties the delay line at once (no clearing pass), sets tap_count to
// one and real_mode to zero; the tap store must be loaded before use.
// Depends on cfir_pkg, cfir_ctrl, cfir_dp, cfir_ram and assert_macros.svh.
module complex_fir_filter_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic        [cfir_pkg::CMD_W-1:0]      cmd,
    input  logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_i,
    input  logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_q,
    input  logic        [cfir_pkg::IDX_W-1:0]      tap_index,
    input  logic signed [cfir_pkg::COEF_W-1:0]     tap_re,
    input  logic signed [cfir_pkg::COEF_W-1:0]     tap_im,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cfir_pkg::SAMPLE_W-1:0]   out_i,
    output logic signed [cfir_pkg::SAMPLE_W-1:0]   out_q,
    output logic                                   clipped,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [cfir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [cfir_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfir_pkg::*;

    `include "assert_macros.svh"

    cfir_cmd_t dp_cmd;
    cfir_sts_t dp_sts;

    cfir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    cfir_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .tap_index (tap_index),
        .tap_re    (tap_re),
        .tap_im    (tap_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q),
        .clipped   (clipped)
    );

    `ASSERT_NEXT(a_filter_goes_busy, in_valid && !in_stall && cmd == CMD_FILTER, in_stall)
    `ASSERT_NEXT(a_other_stays_idle, in_valid && !in_stall && cmd != CMD_FILTER, !in_stall)
    `ASSERT_IMPL(a_result_after_work, $rose(out_valid), $past(in_stall))
    `ASSERT_IMPL(a_no_pipe_when_idle, !in_stall, !dp_sts.pipe_busy && !dp_cmd.issue)

endmodule

// File: test/tb_complex_fir_filter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for complex_fir_filter_core: directed and random command beats,
// an in-bench fixed-point model of the filter and an in-order result scoreboard.
// Depends on cfir_pkg and the filter RTL only.
module tb_complex_fir_filter_core;
    import cfir_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd2;
    localparam int                   DRAIN_CYCLES = MAX_TAPS + 20;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   HOLD_CYCLES  = 400;
    localparam int                   HOLD_AFTER   = 200;
    localparam int                   PHASE_BEATS  = 135;
    localparam longint               Q_MAX        = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint               Q_MIN        = -Q_MAX - 1;
    localparam longint               HALF_LSB     = longint'(1) <<< (COEF_W - 2);

    typedef struct {
        logic        [CMD_W-1:0]    op;
        logic signed [SAMPLE_W-1:0] x_i;
        logic signed [SAMPLE_W-1:0] x_q;
        logic        [IDX_W-1:0]    idx;
        logic signed [COEF_W-1:0]   h_re;
        logic signed [COEF_W-1:0]   h_im;
    } fir_beat_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] y_i;
        logic signed [SAMPLE_W-1:0] y_q;
        logic                       sat;
    } fir_out_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic        [CMD_W-1:0]      cmd = '0;
    logic signed [SAMPLE_W-1:0]   sample_i = '0;
    logic signed [SAMPLE_W-1:0]   sample_q = '0;
    logic        [IDX_W-1:0]      tap_index = '0;
    logic signed [COEF_W-1:0]     tap_re = '0;
    logic signed [COEF_W-1:0]     tap_im = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   out_i;
    logic signed [SAMPLE_W-1:0]   out_q;
    logic                         clipped;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_data = '0;

    fir_beat_t pending_cmds[$];
    fir_out_t  expected_outputs[$];
    fir_beat_t cur_beat;
    logic      beat_taken = 1'b0;
    logic      no_idle = 1'b0;
    logic      hold_used = 1'b0;
    int        hold_left = 0;
    int        beats_accepted = 0;
    int        errors = 0;

    logic signed [SAMPLE_W-1:0] hist_i [MAX_TAPS-1];
    logic signed [SAMPLE_W-1:0] hist_q [MAX_TAPS-1];
    logic signed [COEF_W-1:0]   coef_re [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_im [MAX_TAPS];
    logic        [CFG_DATA_W-1:0] model_taps = 7'd1;
    logic                         model_real = 1'b0;

    complex_fir_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .tap_index (tap_index),
        .tap_re    (tap_re),
        .tap_im    (tap_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q),
        .clipped   (clipped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void clear_history();
        for (int j = 0; j < MAX_TAPS - 1; j++)
        begin
            hist_i[j] = '0;
            hist_q[j] = '0;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] saturate(input longint r);
        if (r > Q_MAX)
            return SAMPLE_W'(Q_MAX);
        if (r < Q_MIN)
            return SAMPLE_W'(Q_MIN);
        return SAMPLE_W'(r);
    endfunction

    task automatic filter_step(input fir_beat_t b);
        longint   acc_i;
        longint   acc_q;
        longint   si;
        longint   sq;
        longint   hr;
        longint   hm;
        longint   ri;
        longint   rq;
        int       n;
        fir_out_t res;
        acc_i = 0;
        acc_q = 0;
        case (b.op)
            CMD_LOAD:
            begin
                coef_re[b.idx] = b.h_re;
                coef_im[b.idx] = b.h_im;
            end
            CMD_CLEAR:
                clear_history();
            CMD_FILTER:
            begin
                n = (model_taps == 0) ? 1 : (model_taps > MAX_TAPS) ? MAX_TAPS : model_taps;
                for (int k = 0; k < n; k++)
                begin
                    si = (k == 0) ? b.x_i : hist_i[k-1];
                    sq = (k == 0) ? b.x_q : hist_q[k-1];
                    hr = coef_re[k];
                    hm = model_real ? 0 : coef_im[k];
                    acc_i += hr * si - hm * sq;
                    acc_q += hr * sq + hm * si;
                end
                for (int j = MAX_TAPS - 2; j > 0; j--)
                begin
                    hist_i[j] = hist_i[j-1];
                    hist_q[j] = hist_q[j-1];
                end
                hist_i[0] = b.x_i;
                hist_q[0] = b.x_q;
                ri = (acc_i + HALF_LSB) >>> (COEF_W - 1);
                rq = (acc_q + HALF_LSB) >>> (COEF_W - 1);
                res.sat = (ri > Q_MAX) || (ri < Q_MIN) || (rq > Q_MAX) || (rq < Q_MIN);
                res.y_i = saturate(ri);
                res.y_q = saturate(rq);
                expected_outputs.push_back(res);
            end
            default:
                ;
        endcase
    endtask

    function automatic void push_beat(input logic [CMD_W-1:0] op, input int xi, input int xq,
                                      input int idx, input int hre, input int him);
        fir_beat_t b;
        b.op   = op;
        b.x_i  = SAMPLE_W'(xi);
        b.x_q  = SAMPLE_W'(xq);
        b.idx  = IDX_W'(idx);
        b.h_re = COEF_W'(hre);
        b.h_im = COEF_W'(him);
        pending_cmds.push_back(b);
    endfunction

    function automatic fir_beat_t random_beat();
        fir_beat_t b;
        int        pick;
        pick = $urandom_range(99);
        b.op = (pick < 86) ? CMD_FILTER : (pick < 96) ? CMD_LOAD :
               (pick < 98) ? CMD_CLEAR : CMD_UNUSED;
        b.x_i  = SAMPLE_W'($urandom);
        b.x_q  = SAMPLE_W'($urandom);
        b.idx  = IDX_W'($urandom);
        b.h_re = COEF_W'($urandom);
        b.h_im = COEF_W'($urandom);
        if ($urandom_range(7) == 0)
            b.x_i = $urandom_range(1) ? SAMPLE_W'(Q_MAX) : SAMPLE_W'(Q_MIN);
        if ($urandom_range(7) == 0)
            b.x_q = $urandom_range(1) ? SAMPLE_W'(Q_MAX) : SAMPLE_W'(Q_MIN);
        if ($urandom_range(1))
        begin
            b.h_re = b.h_re >>> 6;
            b.h_im = b.h_im >>> 6;
        end
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 23))
            begin
                cur_beat = pending_cmds.pop_front();
                cmd       <= cur_beat.op;
                sample_i  <= cur_beat.x_i;
                sample_q  <= cur_beat.x_q;
                tap_index <= cur_beat.idx;
                tap_re    <= cur_beat.h_re;
                tap_im    <= cur_beat.h_im;
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_used && beats_accepted >= HOLD_AFTER)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 23);
    end

    always @(posedge clk)
    begin : check_side
        fir_out_t want;
        beat_taken = rst_n && in_valid && !in_stall;
        if (beat_taken)
        begin
            filter_step(cur_beat);
            beats_accepted++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TAP_COUNT)
                model_taps = cfg_data;
            else if (cfg_index == REG_REAL_MODE)
                model_real = cfg_data[0];
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("result beat with none expected: out_i %0d out_q %0d", out_i, out_q);
                errors++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (out_i !== want.y_i)
                begin
                    $error("out_i: expected %0d, got %0d", want.y_i, out_i);
                    errors++;
                end
                if (out_q !== want.y_q)
                begin
                    $error("out_q: expected %0d, got %0d", want.y_q, out_q);
                    errors++;
                end
                if (clipped !== want.sat)
                begin
                    $error("clipped: expected %0d, got %0d", want.sat, clipped);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("tb_complex_fir_filter_core: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        fir_beat_t b;
        int        phase_taps [6];
        int        phase_real [6];
        clear_history();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset leaves one complex tap in use; tap 0 is loaded before the first sample.
        push_beat(CMD_LOAD, $urandom, $urandom, 0, 1, 0);
        push_beat(CMD_FILTER, 16384, -16384, $urandom, $urandom, $urandom);
        push_beat(CMD_FILTER, -16385, 16385, $urandom, $urandom, $urandom);
        push_beat(CMD_LOAD, $urandom, $urandom, 0, int'(Q_MIN), int'(Q_MIN));
        push_beat(CMD_FILTER, int'(Q_MIN), int'(Q_MIN), $urandom, $urandom, $urandom);
        push_beat(CMD_FILTER, int'(Q_MAX), int'(Q_MIN), $urandom, $urandom, $urandom);
        push_beat(CMD_FILTER, 0, 0, $urandom, $urandom, $urandom);
        push_beat(CMD_LOAD, $urandom, $urandom, 0, int'(Q_MAX), int'(Q_MAX));
        push_beat(CMD_FILTER, int'(Q_MAX), int'(Q_MAX), $urandom, $urandom, $urandom);
        push_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_beat(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_beat(CMD_FILTER, int'(Q_MIN), int'(Q_MAX), $urandom, $urandom, $urandom);
        for (int t = 1; t < MAX_TAPS; t++)
        begin
            b = random_beat();
            b.op = CMD_LOAD;
            b.idx = IDX_W'(t);
            pending_cmds.push_back(b);
        end
        drain();

        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        phase_taps = '{MAX_TAPS, 0, 127, 1, $urandom_range(MAX_TAPS - 1, 2), MAX_TAPS};
        phase_real = '{0, 1, 0, 1, $urandom_range(1), 1};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_TAP_COUNT, CFG_DATA_W'(phase_taps[p]));
            write_reg(REG_REAL_MODE, {6'($urandom), 1'(phase_real[p])});
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_BEATS; n++)
                pending_cmds.push_back(random_beat());
            drain();
        end

        if (errors == 0)
            $display("tb_complex_fir_filter_core: done, clean");
        else
            $display("tb_complex_fir_filter_core: done, errors");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/cfir_pkg.sv
sv/cfir_ram.sv
sv/cfir_ctrl.sv
sv/cfir_dp.sv
sv/complex_fir_filter_core.sv
test/tb_complex_fir_filter_core.sv
